>>> sv/perspective_point_projection_top_assert.svh
// assertion macros shared by the projection block
// relies on clk_i and rst_ni in the module that uses them
`ifndef PERSPECTIVE_POINT_PROJECTION_TOP_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_TOP_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define PPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define PPP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/ppp_pkg.sv
// types and constants of the perspective projection block
// no dependencies
package ppp_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic signed [32:0] LIMIT_MAG = 33'sd10000;
  localparam logic signed [16:0] MIN_DEPTH = 17'sd1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_SKIPPED  = 2'd2;

  localparam logic [1:0] REG_CENTER_X     = 2'd0;
  localparam logic [1:0] REG_CENTER_Y     = 2'd1;
  localparam logic [1:0] REG_GROUND_DEPTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } ppp_state_e;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] ground_depth;
  } ppp_cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic axis;
    logic mul;
    logic div_init;
    logic div_step;
    logic fin;
    logic emit;
  } ppp_cmd_t;

  typedef struct packed {
    logic skip;
    logic bad_depth;
    logic div_last;
  } ppp_stat_t;

endpackage

>>> sv/ppp_ctrl.sv
// controller of the projection block: sequences load, multiply, divide and emit
// depends on ppp_pkg
module ppp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  input  ppp_pkg::ppp_stat_t  stat_i,
  output ppp_pkg::ppp_cmd_t   cmd_o
);

  ppp_pkg::ppp_state_e state_q, state_d;
  logic                axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppp_pkg::ST_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ppp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ppp_pkg::ST_PREP;
          axis_d  = 1'b0;
        end
      end
      ppp_pkg::ST_PREP:  state_d = ppp_pkg::ST_MUL;
      ppp_pkg::ST_MUL: begin
        if (stat_i.skip || stat_i.bad_depth) state_d = ppp_pkg::ST_OUT;
        else                                 state_d = ppp_pkg::ST_DINIT;
      end
      ppp_pkg::ST_DINIT: state_d = ppp_pkg::ST_DIV;
      ppp_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = ppp_pkg::ST_FIN;
      end
      ppp_pkg::ST_FIN: begin
        if (axis_q) begin
          state_d = ppp_pkg::ST_OUT;
        end else begin
          state_d = ppp_pkg::ST_MUL;
          axis_d  = 1'b1;
        end
      end
      ppp_pkg::ST_OUT: begin
        if (out_free_i) state_d = ppp_pkg::ST_IDLE;
      end
      default: state_d = ppp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    case (state_q)
      ppp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ppp_pkg::ST_PREP:  cmd_o.prep     = 1'b1;
      ppp_pkg::ST_MUL:   cmd_o.mul      = 1'b1;
      ppp_pkg::ST_DINIT: cmd_o.div_init = 1'b1;
      ppp_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      ppp_pkg::ST_FIN:   cmd_o.fin      = 1'b1;
      ppp_pkg::ST_OUT:   cmd_o.emit     = out_free_i;
      default: ;
    endcase
  end

endmodule

>>> sv/ppp_dp.sv
// datapath of the projection block: depth, product, serial divider, result
// depends on ppp_pkg and perspective_point_projection_top_assert.svh
`include "perspective_point_projection_top_assert.svh"

module ppp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppp_pkg::ppp_cfg_t   cfg_i,
  input  ppp_pkg::ppp_cmd_t   cmd_i,
  output ppp_pkg::ppp_stat_t  stat_o,
  input  logic [47:0]         in_data_i,
  input  logic                in_last_i,
  output logic [15:0]         screen_x_o,
  output logic [15:0]         screen_y_o,
  output logic [1:0]          status_o,
  output logic                last_o
);

  logic signed [15:0] px_q, py_q, pz_q;
  logic               last_q;
  logic signed [16:0] depth_q;
  logic               skip_q, bad_q;
  logic               list_failed_q;
  logic [31:0]        prod_q;
  logic               neg_q;
  logic [31:0]        quo_q;
  logic [17:0]        rem_q;
  logic [ppp_pkg::CNT_W-1:0] cnt_q;
  logic signed [32:0] res_x_q, res_y_q;
  logic [15:0]        sx_q, sy_q;
  logic [1:0]         st_q;
  logic               lo_q;

  logic signed [16:0] depth_d;
  logic signed [16:0] diff;
  logic signed [32:0] prod_full;
  logic [17:0]        rem_sh;
  logic               fits;
  logic [17:0]        rem_next;
  logic signed [32:0] quo_s;
  logic signed [32:0] res;
  logic               range_bad;
  logic [1:0]         st_d;

  assign depth_d   = 17'(pz_q) + 17'(cfg_i.ground_depth);
  assign diff      = cmd_i.axis ? (17'(py_q) - 17'(cfg_i.center_y))
                                : (17'(px_q) - 17'(cfg_i.center_x));
  assign prod_full = 33'(diff) * 33'(cfg_i.ground_depth);

  // restoring division, one quotient bit a cycle
  assign rem_sh   = {rem_q[16:0], quo_q[31]};
  assign fits     = rem_sh >= {1'b0, depth_q};
  assign rem_next = fits ? (rem_sh - {1'b0, depth_q}) : rem_sh;

  // signed quotient truncated toward zero, then shift back by the center
  assign quo_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign res   = quo_s + (cmd_i.axis ? 33'(cfg_i.center_y) : 33'(cfg_i.center_x));

  assign range_bad = (res_x_q < -ppp_pkg::LIMIT_MAG) || (res_x_q > ppp_pkg::LIMIT_MAG) ||
                     (res_y_q < -ppp_pkg::LIMIT_MAG) || (res_y_q > ppp_pkg::LIMIT_MAG);

  always_comb begin
    if (skip_q)         st_d = ppp_pkg::STAT_SKIPPED;
    else if (bad_q)     st_d = ppp_pkg::STAT_OVERFLOW;
    else if (range_bad) st_d = ppp_pkg::STAT_OVERFLOW;
    else                st_d = ppp_pkg::STAT_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_failed_q <= 1'b0;
    end else if (cmd_i.emit) begin
      list_failed_q <= last_q ? 1'b0 : (st_d != ppp_pkg::STAT_OK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= in_data_i[15:0];
      py_q   <= in_data_i[31:16];
      pz_q   <= in_data_i[47:32];
      last_q <= in_last_i;
    end
    if (cmd_i.prep) begin
      depth_q <= depth_d;
      bad_q   <= depth_d < ppp_pkg::MIN_DEPTH;
      skip_q  <= list_failed_q;
    end
    if (cmd_i.mul) begin
      // magnitude stays below 2^31, so the low 32 bits are exact
      prod_q <= prod_full[31:0];
    end
    if (cmd_i.div_init) begin
      neg_q <= prod_q[31];
      quo_q <= prod_q[31] ? (32'd0 - prod_q) : prod_q;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[30:0], fits};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.fin) begin
      if (cmd_i.axis) res_y_q <= res;
      else            res_x_q <= res;
    end
    if (cmd_i.emit) begin
      sx_q <= (skip_q || bad_q) ? 16'd0 : res_x_q[15:0];
      sy_q <= (skip_q || bad_q) ? 16'd0 : res_y_q[15:0];
      st_q <= st_d;
      lo_q <= last_q;
    end
  end

  assign stat_o.skip      = skip_q;
  assign stat_o.bad_depth = bad_q;
  assign stat_o.div_last  = cnt_q == ppp_pkg::CNT_W'(ppp_pkg::DIV_STEPS - 1);

  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign status_o   = st_q;
  assign last_o     = lo_q;

  `PPP_ASSERT(a_rem_below_depth, cmd_i.div_step |-> (rem_q < {1'b0, depth_q}),
              "divider remainder not below depth")
  `PPP_ASSERT(a_skip_status, (cmd_i.emit && skip_q) |=> (st_q == ppp_pkg::STAT_SKIPPED),
              "skipped point not reported as skipped")
  `PPP_ASSERT(a_last_clears, (cmd_i.emit && last_q) |=> !list_failed_q,
              "list error not cleared after last point")

endmodule

>>> sv/perspective_point_projection_top.sv
// perspective projection: each accepted word goes through prep, then per axis one
// multiply, one divider load, 32 divide steps and one fixup, then emit; both axes use
// the shared bit-serial divider in turn, and a new word is taken only once the last
// result is emitted; skipped or bad-depth points go from multiply straight to emit
// rst_ni is asynchronous, active low: resets control, list error flag and config registers
// depends on ppp_pkg, ppp_ctrl, ppp_dp and perspective_point_projection_top_assert.svh
`include "perspective_point_projection_top_assert.svh"

module perspective_point_projection_top #(
  parameter int unsigned CFG_INDEX_W = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  // input points
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,  // point_x, point_y, point_z
  input  logic                   s_axis_tlast,  // is_last
  // projected points
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,  // screen_x, screen_y
  output logic [1:0]             m_axis_tuser,  // status
  output logic                   m_axis_tlast   // last_out
);

  ppp_pkg::ppp_cfg_t  cfg_q;
  ppp_pkg::ppp_cmd_t  cmd;
  ppp_pkg::ppp_stat_t stat;
  logic               m_valid_q;
  logic               out_free;
  logic [15:0]        screen_x, screen_y;

  // config registers, always ready; writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.ground_depth <= 16'sd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INDEX_W'(ppp_pkg::REG_CENTER_X):     cfg_q.center_x     <= cfg_data_i;
        CFG_INDEX_W'(ppp_pkg::REG_CENTER_Y):     cfg_q.center_y     <= cfg_data_i;
        CFG_INDEX_W'(ppp_pkg::REG_GROUND_DEPTH): cfg_q.ground_depth <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output slot: free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  ppp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ppp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .screen_x_o (screen_x),
    .screen_y_o (screen_y),
    .status_o   (m_axis_tuser),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {screen_y, screen_x};

  // a new result may only land in a free output slot
  `PPP_NEVER(a_emit_overwrite, cmd.emit && m_valid_q && !m_axis_tready,
             "result emitted over a pending word")
  // input is taken only when the controller is not busy with an item
  `PPP_ASSERT(a_no_accept_busy, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
              "input accepted while an item is in flight")

endmodule

>>> verif/ppp_checker.sv
`timescale 1ns / 1ps
// scoreboard for the perspective projection block: taps the register, point and result channels
// predicts every projected point and compares it field by field; depends on ppp_pkg
module ppp_checker #(
  parameter int unsigned IDX_W = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [47:0]      s_axis_tdata,   // point_x, point_y, point_z
  input  logic             s_axis_tlast,   // is_last
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [31:0]      m_axis_tdata,   // screen_x, screen_y
  input  logic [1:0]       m_axis_tuser,   // status
  input  logic             m_axis_tlast,   // last_out
  output int               fail_count_o,
  output int               pending_o,
  output int               ok_cnt_o,
  output int               ovf_cnt_o,
  output int               skip_cnt_o
);

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [1:0]         status;
    logic               last;
  } screen_pt_t;

  logic signed [15:0] cx_q, cy_q, gd_q;
  logic               list_err;
  screen_pt_t         screen_q[$];
  screen_pt_t         exp_pt;

  function automatic logic signed [15:0] proj_axis(input logic signed [15:0] coord,
                                                  input logic signed [15:0] centre,
                                                  input longint depth,
                                                  output logic oob);
    longint r;
    r = (longint'(coord) - longint'(centre)) * longint'(gd_q) / depth + longint'(centre);
    oob = (r < -longint'(ppp_pkg::LIMIT_MAG)) || (r > longint'(ppp_pkg::LIMIT_MAG));
    return r[15:0];
  endfunction

  // one projected point per word; also advances the list error flag
  function automatic screen_pt_t project_point(input logic [15:0] px, input logic [15:0] py,
                                               input logic [15:0] pz, input logic last);
    screen_pt_t r;
    longint     depth;
    logic       oob_x, oob_y;
    r = '0;
    r.last = last;
    if (list_err) begin
      r.status = ppp_pkg::STAT_SKIPPED;
    end else begin
      depth = longint'($signed(pz)) + longint'(gd_q);
      if (depth < longint'(ppp_pkg::MIN_DEPTH)) begin
        r.status = ppp_pkg::STAT_OVERFLOW;
        list_err = 1'b1;
      end else begin
        r.sx = proj_axis(px, cx_q, depth, oob_x);
        r.sy = proj_axis(py, cy_q, depth, oob_y);
        if (oob_x || oob_y) begin
          r.status = ppp_pkg::STAT_OVERFLOW;
          list_err = 1'b1;
        end else begin
          r.status = ppp_pkg::STAT_OK;
        end
      end
    end
    if (last) list_err = 1'b0;
    return r;
  endfunction

  task automatic check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q         = '0;
      cy_q         = '0;
      gd_q         = 16'sd1;
      list_err     = 1'b0;
      screen_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      ok_cnt_o     = 0;
      ovf_cnt_o    = 0;
      skip_cnt_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ppp_pkg::REG_CENTER_X:     cx_q = cfg_data_i;
          ppp_pkg::REG_CENTER_Y:     cy_q = cfg_data_i;
          ppp_pkg::REG_GROUND_DEPTH: gd_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        screen_q.push_back(project_point(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                         s_axis_tdata[47:32], s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (screen_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result word, expected none, got x %0d y %0d status %0d",
                   $time, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                   m_axis_tuser);
        end else begin
          exp_pt = screen_q.pop_front();
          check_field("screen_x", exp_pt.sx, $signed(m_axis_tdata[15:0]));
          check_field("screen_y", exp_pt.sy, $signed(m_axis_tdata[31:16]));
          check_field("status", exp_pt.status, m_axis_tuser);
          check_field("last_out", exp_pt.last, m_axis_tlast);
          case (exp_pt.status)
            ppp_pkg::STAT_OK:       ok_cnt_o++;
            ppp_pkg::STAT_OVERFLOW: ovf_cnt_o++;
            default:                skip_cnt_o++;
          endcase
        end
      end
      pending_o = screen_q.size();
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// top of the perspective projection testbench: clock, reset, register writes and point lists
// depends on ppp_pkg, perspective_point_projection_top and ppp_checker
module tb_top;

  // index past the register list, writes there must be ignored
  localparam logic [1:0] REG_NONE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // point_x, point_y, point_z
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // screen_x, screen_y
  logic [1:0]  m_axis_tuser;   // status
  logic        m_axis_tlast;   // last_out

  int fail_cnt, pending, ok_cnt, ovf_cnt, skip_cnt;

  // what the stimulus side believes the registers hold, used to aim the points
  logic signed [15:0] cur_cx, cur_cy, cur_gd;
  logic [15:0]        px, py, pz, ncx, ncy, ngd;
  logic               lst;
  int unsigned        n_points, n_lists, n_settings;
  int unsigned        len, sent_phase, kind;
  bit                 burst, broken;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  perspective_point_projection_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ppp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_cnt),
    .pending_o     (pending),
    .ok_cnt_o      (ok_cnt),
    .ovf_cnt_o     (ovf_cnt),
    .skip_cnt_o    (skip_cnt)
  );

  // mostly short pauses, some spanning a good part of one point's work, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 90);
    return $urandom_range(91, 400);
  endfunction

  function automatic logic [15:0] edge_val();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'hffff;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7fff;
    endcase
  endfunction

  // valid stays high from one word to the next unless a pause is asked for
  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                            input logic last, input int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_points++;
    if (last) n_lists++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // registers only change once every point in flight has come back out
  task automatic set_config(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] gd);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    write_reg(ppp_pkg::REG_CENTER_X, cx);
    write_reg(ppp_pkg::REG_CENTER_Y, cy);
    if ($urandom_range(0, 1)) write_reg(REG_NONE, 16'($urandom));
    write_reg(ppp_pkg::REG_GROUND_DEPTH, gd);
    cfg_valid_i <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
    cur_gd = gd;
    n_settings++;
  endtask

  // random result back-pressure: ready runs, sometimes long calm ones, then stalls
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 600 : 25)) @(posedge clk_i);
      m_axis_tready <= 1'b0;
      repeat (idle_len() + 1) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    n_points      = 0;
    n_lists       = 0;
    n_settings    = 0;
    cur_cx        = '0;
    cur_cy        = '0;
    cur_gd        = 16'sd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, unit scale so the result equals the coordinate
    send_point(16'd0, 16'd0, 16'd0, 1'b1, 0);
    send_point(16'd10000, -16'sd10000, 16'd0, 1'b0, idle_len());   // range edge still ok
    send_point(16'd10001, 16'd0, 16'd0, 1'b1, idle_len());         // x just past range
    send_point(16'd0, -16'sd10001, 16'd0, 1'b1, idle_len());       // y just past range
    send_point(16'h7fff, 16'h8000, 16'd0, 1'b0, idle_len());       // error mid list
    send_point(16'd0, 16'd0, 16'd0, 1'b0, idle_len());             // skipped
    send_point(16'd1, 16'd1, 16'd1, 1'b1, idle_len());             // skipped, list closes
    send_point(16'd0, 16'd0, 16'hffff, 1'b1, idle_len());          // depth zero
    send_point(16'd100, -16'sd100, 16'h7fff, 1'b1, idle_len());

    // moderate scale, offset centre, negative quotient truncates toward zero
    set_config(16'd10, -16'sd20, 16'd100);
    send_point(16'd50, -16'sd120, 16'd0, 1'b1, 0);
    send_point(-16'sd3, -16'sd20, 16'd200, 1'b1, idle_len());
    send_point(16'd0, 16'd0, -16'sd100, 1'b1, idle_len());

    // extreme registers: largest products and negative depth
    set_config(16'h8000, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h7fff, 16'd0, 1'b1, 0);
    send_point(16'h7fff, 16'h8000, -16'sd32766, 1'b1, idle_len());
    send_point(16'd0, 16'd0, 16'h8000, 1'b1, idle_len());

    // out of range in full precision though the low bits look small
    set_config(16'd0, 16'd0, 16'h7fff);
    send_point(16'd2, 16'd0, -16'sd32766, 1'b1, 0);
    send_point(16'h8000, 16'h8000, -16'sd32766, 1'b0, idle_len());
    send_point(16'd0, 16'd0, 16'd0, 1'b1, idle_len());

    // zero scale: every projection collapses onto the centre
    set_config(16'd0, 16'd0, 16'd0);
    send_point(16'd12345, -16'sd12345, 16'd1, 1'b1, 0);
    send_point(16'd0, 16'd0, 16'd0, 1'b1, idle_len());

    // most negative ground depth: no depth can reach one
    set_config(16'd0, 16'd0, 16'h8000);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b1, idle_len());

    // random phases: each gets fresh registers, then point lists aimed at the screen
    for (int ph = 0; ph < 10; ph++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        ncx = 16'($urandom_range(0, 1000) - 500);
        ncy = 16'($urandom_range(0, 1000) - 500);
        ngd = 16'($urandom_range(1, 4000));
      end else if (kind < 8) begin
        ncx = 16'($urandom);
        ncy = 16'($urandom);
        ngd = 16'($urandom);
      end else begin
        ncx = edge_val();
        ncy = edge_val();
        ngd = edge_val();
      end
      set_config(ncx, ncy, ngd);
      burst      = ($urandom_range(0, 3) == 0);
      sent_phase = 0;
      while (sent_phase < 130) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 12) begin
            // noise: anything the fields allow
            px = 16'($urandom);
            py = 16'($urandom);
            pz = 16'($urandom);
          end else begin
            px = 16'(cur_cx + $urandom_range(0, 16000) - 8000);
            py = 16'(cur_cy + $urandom_range(0, 16000) - 8000);
            case ($urandom_range(0, 9))
              0:       pz = 16'(-cur_gd + $urandom_range(0, 2));   // hugging the depth limit
              1:       pz = 16'($urandom_range(0, 600) - 300);
              default: pz = 16'($urandom_range(0, 3000));
            endcase
          end
          lst = broken ? 1'($urandom_range(0, 1)) : (k == len - 1);
          send_point(px, py, pz, lst, burst ? 0 : idle_len());
          sent_phase++;
        end
      end
    end

    // drain, then give a stray extra word time to show up
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("covered %0d points in %0d lists under %0d register settings",
             n_points, n_lists, n_settings);
    $display("results: %0d ok, %0d overflow, %0d skipped", ok_cnt, ovf_cnt, skip_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
